FILE: rtl/pphf_pkg.sv
// pphf_pkg: shared constants, codes and control types of the pedestal, common mode
// and hit finder block
// no dependencies
package pphf_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SMP_W  = 16;
    localparam int IDX_W  = 12;
    localparam int SIG_W  = 21;
    localparam int MASK_W = 8;

    localparam int PHASE_W = 2;
    localparam int DIM_W   = 7;
    localparam int FLOG_W  = 5;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 7;

    localparam int PSUM_W   = 32;
    localparam int NSUM_W   = 56;
    localparam int NTOT_W   = 64;
    localparam int LIM_W    = 48;
    localparam int FCNT_W   = 17;
    localparam int FLOG_MAX = 16;

    localparam int DVD_W = NTOT_W + 5;
    localparam int SQ_W  = 2 * SIG_W;
    localparam int SQS_W = SQ_W + FLOG_MAX;
    localparam int N9_W  = NSUM_W + 4;

    localparam int SIG_MAX = 2 ** (SIG_W - 1) - 1;
    localparam int SIG_MIN = -(2 ** (SIG_W - 1));

    localparam logic [DIM_W-1:0]  ROWS_RST = 7'd64;
    localparam logic [DIM_W-1:0]  COLS_RST = 7'd64;
    localparam logic [FLOG_W-1:0] FLOG_RST = 5'd10;
    localparam logic [FLOG_W-1:0] FLOG_LIM = 5'd16;
    localparam logic [FCNT_W-1:0] FCNT_MAX = '1;

    typedef enum logic [PHASE_W-1:0] {
        PH_PED   = 2'd0,
        PH_NOISE = 2'd1,
        PH_OUT   = 2'd2,
        PH_OFF   = 2'd3
    } t_phase;

    typedef enum logic [CFG_IW-1:0] {
        CFG_PHASE = 2'd0,
        CFG_ROWS  = 2'd1,
        CFG_COLS  = 2'd2,
        CFG_FLOG  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_PED,
        ST_UPD,
        ST_CM,
        ST_CM_W,
        ST_LIM,
        ST_LIM_W,
        ST_RRD,
        ST_RPED,
        ST_RSIG,
        ST_RSQ,
        ST_REVAL,
        ST_RLOAD,
        ST_RWAIT
    } t_state;

    typedef struct packed {
        logic take;
        logic clr;
        logic rd_rp;
        logic ped_calc;
        logic smp_upd;
        logic adv;
        logic cm_start;
        logic cm_load;
        logic lim_start;
        logic lim_load;
        logic rp_init;
        logic sig_calc;
        logic sq_calc;
        logic eval;
        logic out_load;
        logic rp_step;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   grp_end;
        logic   div_done;
        logic   clr_last;
        logic   out_xfer;
        logic   rp_last;
    } t_sts;

endpackage

FILE: rtl/pphf_in_if.sv
// pphf_in_if: raw sample stream, valid/ready transfer
// depends on pphf_pkg
interface pphf_in_if import pphf_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/pphf_out_if.sv
// pphf_out_if: corrected pixel result stream, valid/ready transfer
// depends on pphf_pkg
interface pphf_out_if import pphf_pkg::*;;
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    pixel_index;
    logic signed [SIG_W-1:0] signal;
    logic                hit;
    logic                hot;
    logic                edge_res;
    logic [MASK_W-1:0]   neighbour_mask;
    logic                last_of_group;
    logic                last_of_frame;

    modport source (output valid, output pixel_index, output signal, output hit,
                    output hot, output edge_res, output neighbour_mask,
                    output last_of_group, output last_of_frame, input ready);
    modport sink   (input valid, input pixel_index, input signal, input hit,
                    input hot, input edge_res, input neighbour_mask,
                    input last_of_group, input last_of_frame, output ready);
endinterface

FILE: rtl/pphf_div.sv
// pphf_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies
module pphf_div #(
    parameter int N_BITS = 69,
    parameter int D_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N_BITS-1:0] i_dividend,
    input  logic [D_BITS-1:0] i_divisor,
    output logic              o_done,
    output logic [N_BITS-1:0] o_quot,
    output logic [D_BITS-1:0] o_rem
);
    localparam int CNT_W = $clog2(N_BITS + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [N_BITS-1:0] r_q;
    logic [D_BITS-1:0] r_rem;
    logic [D_BITS-1:0] r_d;

    logic [D_BITS:0]   trial;
    logic [D_BITS:0]   trial_sub;
    logic              ge;
    logic [D_BITS-1:0] n_rem;

    assign trial     = {r_rem, r_q[N_BITS-1]};
    assign trial_sub = trial - {1'b0, r_d};
    assign ge        = trial >= {1'b0, r_d};
    assign n_rem     = ge ? trial_sub[D_BITS-1:0] : trial[D_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(N_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[N_BITS-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

FILE: rtl/pphf_dp.sv
// pphf_dp: datapath with configuration registers, frame counters, per-pixel sum memories,
// group buffer, divider and result register
// depends on pphf_pkg, pphf_out_if and pphf_div
module pphf_dp import pphf_pkg::*; #(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic [SMP_W-1:0]  i_sample,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    pphf_out_if.source        o_res
);
    localparam int NPIX   = MAX_ROWS * MAX_COLS;
    localparam int PIX_W  = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int N_W    = $clog2(NPIX + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int BUF_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PED_W  = SAMPLE_BITS + 4;
    localparam int DIFF_W = SAMPLE_BITS + 5;
    localparam int GS_W   = DIFF_W + $clog2(MAX_ROWS + 1);
    localparam int SX_W   = (GS_W + 1 > SIG_W + 1) ? GS_W + 1 : SIG_W + 1;
    localparam int DVS_W  = $clog2(2 * NPIX + 1);

    // configuration
    t_phase            r_phase;
    logic [DIM_W-1:0]  r_rows;
    logic [DIM_W-1:0]  r_cols;
    logic [FLOG_W-1:0] r_flog;

    // counters and running state
    logic [PIX_W-1:0]  r_pix;
    logic [ROW_W-1:0]  r_pos;
    logic [FCNT_W-1:0] r_frame;
    logic signed [GS_W-1:0] r_gsum;
    logic [NTOT_W-1:0] r_total;
    logic [LIM_W-1:0]  r_limit;
    logic [PIX_W-1:0]  r_clr_addr;
    logic [PIX_W-1:0]  r_rp_idx;
    logic [ROW_W-1:0]  r_rp_j;
    logic [ROW_W-1:0]  r_rp_row;
    logic [COL_W-1:0]  r_rp_col;
    logic              r_out_valid;

    // memories
    logic [PSUM_W-1:0]      mem_ped   [NPIX];
    logic [NSUM_W-1:0]      mem_noise [NPIX];
    logic [SAMPLE_BITS-1:0] mem_buf   [MAX_ROWS];

    // payload registers
    logic [SAMPLE_BITS-1:0] r_smp;
    logic [PSUM_W-1:0]      r_ped_rd;
    logic [NSUM_W-1:0]      r_noise_rd;
    logic [SAMPLE_BITS-1:0] r_buf_rd;
    logic [PED_W-1:0]       r_ped;
    logic signed [GS_W-1:0] r_cm;
    logic signed [SIG_W-1:0] r_sig;
    logic [SQ_W-1:0]        r_sq;
    logic                   r_hot;
    logic [SQS_W-1:0]       r_sqs;
    logic [N9_W-1:0]        r_n9;
    logic [IDX_W-1:0]       r_o_idx;
    logic signed [SIG_W-1:0] r_o_sig;
    logic                   r_o_hit;
    logic                   r_o_hot;
    logic                   r_o_edge;
    logic [MASK_W-1:0]      r_o_mask;
    logic                   r_o_log;
    logic                   r_o_lof;

    // combinational
    logic [ROW_W-1:0]  eff_r;
    logic [COL_W-1:0]  eff_c;
    logic [N_W-1:0]    npix;
    logic [FLOG_W-1:0] eff_f;
    logic              acc;
    logic              grp_end;
    logic              frame_end;
    logic              cfg_restart;
    logic              restart;
    logic [PIX_W-1:0]  rd_addr;
    logic [PSUM_W+3:0] ped_sh;
    logic [PSUM_W+3:0] ped_cap;
    logic signed [DIFF_W-1:0] diff_s;
    logic signed [DIFF_W-1:0] diff_b;
    logic [PSUM_W:0]   psum_add;
    logic [NSUM_W:0]   nsum_add;
    logic [NTOT_W:0]   ntot_add;
    logic signed [SX_W-1:0] sx;
    logic signed [SIG_W-1:0] sig_sat;
    logic [SIG_W-1:0]  mag;
    logic              ped_we;
    logic [PIX_W-1:0]  ped_wa;
    logic [PSUM_W-1:0] ped_wd;
    logic              noise_we;
    logic [PIX_W-1:0]  noise_wa;
    logic [NSUM_W-1:0] noise_wd;
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;
    logic [DVS_W-1:0]  div_rem;
    logic [GS_W-1:0]   gs_mag;
    logic signed [GS_W-1:0] cm_mag;
    logic              hit;
    logic              edge_r0;
    logic              edge_c0;
    logic              edge_rl;
    logic              edge_cl;
    logic [MASK_W-1:0] mask;
    logic [PIX_W+IDX_W-1:0] idx_ext;

    always_comb begin
        if (r_rows == '0) begin
            eff_r = ROW_W'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            eff_r = ROW_W'(MAX_ROWS);
        end else begin
            eff_r = ROW_W'(r_rows);
        end
        if (r_cols == '0) begin
            eff_c = COL_W'(1);
        end else if (int'(r_cols) > MAX_COLS) begin
            eff_c = COL_W'(MAX_COLS);
        end else begin
            eff_c = COL_W'(r_cols);
        end
    end

    assign npix        = N_W'(eff_r) * N_W'(eff_c);
    assign eff_f       = (r_flog > FLOG_LIM) ? FLOG_LIM : r_flog;
    assign acc         = r_frame < (FCNT_W'(1) << eff_f);
    assign grp_end     = r_pos == eff_r - ROW_W'(1);
    assign frame_end   = (N_W'(r_pix) + N_W'(1)) == npix;
    assign cfg_restart = i_cfg_we && (i_cfg_idx != CFG_FLOG);
    assign restart     = cfg_restart || (i_cmd.adv && frame_end);
    assign rd_addr     = i_cmd.rd_rp ? r_rp_idx : r_pix;

    // pedestal in Q4, capped at the largest sample
    assign ped_sh  = {r_ped_rd, 4'b0} >> eff_f;
    assign ped_cap = (PSUM_W + 4)'({{SAMPLE_BITS{1'b1}}, 4'b0});

    assign diff_s = $signed({1'b0, r_smp, 4'b0}) - $signed({1'b0, r_ped});
    assign diff_b = $signed({1'b0, r_buf_rd, 4'b0}) - $signed({1'b0, r_ped});

    assign psum_add = {1'b0, r_ped_rd} + (PSUM_W + 1)'(r_smp);
    assign nsum_add = {1'b0, r_noise_rd} + (NSUM_W + 1)'(r_sq);
    assign ntot_add = {1'b0, r_total} + (NTOT_W + 1)'(r_sq);

    assign sx = SX_W'(diff_b) - SX_W'(r_cm);
    always_comb begin
        if (sx > SX_W'(SIG_MAX)) begin
            sig_sat = SIG_W'(SIG_MAX);
        end else if (sx < SX_W'(SIG_MIN)) begin
            sig_sat = SIG_W'(SIG_MIN);
        end else begin
            sig_sat = SIG_W'(sx);
        end
    end

    assign mag = r_sig[SIG_W-1] ? SIG_W'(-r_sig) : SIG_W'(r_sig);

    // memory write ports
    always_comb begin
        ped_we   = i_cmd.clr || (i_cmd.smp_upd && r_phase == PH_PED && acc);
        ped_wa   = i_cmd.clr ? r_clr_addr : r_pix;
        ped_wd   = '0;
        if (!i_cmd.clr) begin
            ped_wd = psum_add[PSUM_W] ? '1 : psum_add[PSUM_W-1:0];
        end
        noise_we = i_cmd.clr || (i_cmd.eval && r_phase == PH_NOISE && acc);
        noise_wa = i_cmd.clr ? r_clr_addr : r_rp_idx;
        noise_wd = '0;
        if (!i_cmd.clr) begin
            noise_wd = nsum_add[NSUM_W] ? '1 : nsum_add[NSUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ped_we) begin
            mem_ped[ped_wa] <= ped_wd;
        end
        r_ped_rd <= mem_ped[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (noise_we) begin
            mem_noise[noise_wa] <= noise_wd;
        end
        r_noise_rd <= mem_noise[r_rp_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_upd && r_phase != PH_PED) begin
            mem_buf[r_pos[BUF_AW-1:0]] <= r_smp;
        end
        r_buf_rd <= mem_buf[r_rp_j[BUF_AW-1:0]];
    end

    // shared divider: common mode, then hot limit
    assign div_start = i_cmd.cm_start || i_cmd.lim_start;
    assign gs_mag    = r_gsum[GS_W-1] ? GS_W'(-r_gsum) : GS_W'(r_gsum);
    always_comb begin
        if (i_cmd.lim_start) begin
            div_dvd = DVD_W'({r_total, 4'b0}) + DVD_W'(r_total);
            div_dvs = DVS_W'({npix, 1'b0});
        end else begin
            div_dvd = DVD_W'(gs_mag);
            div_dvs = DVS_W'(eff_r);
        end
    end

    pphf_div #(
        .N_BITS (DVD_W),
        .D_BITS (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_rem)
    );

    assign cm_mag = $signed(div_q[GS_W-1:0]);

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PED;
            r_rows  <= ROWS_RST;
            r_cols  <= COLS_RST;
            r_flog  <= FLOG_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PHASE: r_phase <= t_phase'(i_cfg_data[PHASE_W-1:0]);
                CFG_ROWS:  r_rows  <= i_cfg_data[DIM_W-1:0];
                CFG_COLS:  r_cols  <= i_cfg_data[DIM_W-1:0];
                CFG_FLOG:  r_flog  <= i_cfg_data[FLOG_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix   <= '0;
            r_pos   <= '0;
            r_gsum  <= '0;
            r_frame <= '0;
        end else if (restart) begin
            r_pix  <= '0;
            r_pos  <= '0;
            r_gsum <= '0;
            if (i_cfg_we && i_cfg_idx == CFG_PHASE) begin
                r_frame <= '0;
            end else if (!cfg_restart && r_frame != FCNT_MAX) begin
                r_frame <= r_frame + FCNT_W'(1);
            end
        end else if (i_cmd.adv) begin
            r_pix <= r_pix + PIX_W'(1);
            if (grp_end) begin
                r_pos  <= '0;
                r_gsum <= '0;
            end else begin
                r_pos <= r_pos + ROW_W'(1);
                if (i_cmd.smp_upd && r_phase != PH_PED) begin
                    r_gsum <= r_gsum + GS_W'(diff_s);
                end
            end
        end else if (i_cmd.smp_upd && r_phase != PH_PED) begin
            r_gsum <= r_gsum + GS_W'(diff_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp_row <= '0;
            r_rp_col <= '0;
        end else if (restart) begin
            r_rp_row <= '0;
            r_rp_col <= '0;
        end else if (i_cmd.rp_step) begin
            if (r_rp_col == eff_c - COL_W'(1)) begin
                r_rp_col <= '0;
                r_rp_row <= r_rp_row + ROW_W'(1);
            end else begin
                r_rp_col <= r_rp_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp_idx <= '0;
            r_rp_j   <= '0;
        end else if (i_cmd.rp_init) begin
            r_rp_idx <= r_pix - PIX_W'(r_pos);
            r_rp_j   <= '0;
        end else if (i_cmd.rp_step) begin
            r_rp_idx <= r_rp_idx + PIX_W'(1);
            r_rp_j   <= r_rp_j + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_limit <= '0;
        end else begin
            if (i_cmd.eval && r_phase == PH_NOISE && acc) begin
                r_total <= ntot_add[NTOT_W] ? '1 : ntot_add[NTOT_W-1:0];
            end
            if (i_cmd.lim_load) begin
                r_limit <= (|div_q[DVD_W-1:LIM_W]) ? '1 : div_q[LIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + PIX_W'(1);
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_smp <= i_sample[SAMPLE_BITS-1:0];
        end
        if (i_cmd.ped_calc) begin
            r_ped <= (ped_sh > ped_cap) ? ped_cap[PED_W-1:0] : ped_sh[PED_W-1:0];
        end
        if (i_cmd.cm_load) begin
            r_cm <= r_gsum[GS_W-1] ? (-cm_mag - GS_W'(div_rem != '0)) : cm_mag;
        end
        if (i_cmd.sig_calc) begin
            r_sig <= sig_sat;
        end
        if (i_cmd.sq_calc) begin
            r_sq <= SQ_W'(mag) * SQ_W'(mag);
        end
        if (i_cmd.eval) begin
            r_hot <= r_noise_rd > NSUM_W'(r_limit);
            r_sqs <= SQS_W'(r_sq) << eff_f;
            r_n9  <= N9_W'({r_noise_rd, 3'b0}) + N9_W'(r_noise_rd);
        end
    end

    // result register
    assign hit     = !r_hot && (N9_W'(r_sqs) > r_n9);
    assign edge_r0 = r_rp_row == '0;
    assign edge_c0 = r_rp_col == '0;
    assign edge_rl = r_rp_row == eff_r - ROW_W'(1);
    assign edge_cl = r_rp_col == eff_c - COL_W'(1);
    assign idx_ext = {{IDX_W{1'b0}}, r_rp_idx};

    always_comb begin
        mask = '0;
        if (hit) begin
            mask = '1;
            if (edge_r0) begin
                mask[5] = 1'b0;
                mask[6] = 1'b0;
                mask[7] = 1'b0;
            end
            if (edge_c0) begin
                mask[0] = 1'b0;
                mask[3] = 1'b0;
                mask[5] = 1'b0;
            end
            if (edge_rl) begin
                mask[0] = 1'b0;
                mask[1] = 1'b0;
                mask[2] = 1'b0;
            end
            if (edge_cl) begin
                mask[2] = 1'b0;
                mask[4] = 1'b0;
                mask[7] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_idx  <= idx_ext[IDX_W-1:0];
            r_o_sig  <= r_sig;
            r_o_hit  <= hit;
            r_o_hot  <= r_hot;
            r_o_edge <= edge_r0 || edge_c0 || edge_rl || edge_cl;
            r_o_mask <= mask;
            r_o_log  <= r_rp_j == eff_r - ROW_W'(1);
            r_o_lof  <= (N_W'(r_rp_idx) + N_W'(1)) == npix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.pixel_index    = r_o_idx;
    assign o_res.signal         = r_o_sig;
    assign o_res.hit            = r_o_hit;
    assign o_res.hot            = r_o_hot;
    assign o_res.edge_res       = r_o_edge;
    assign o_res.neighbour_mask = r_o_mask;
    assign o_res.last_of_group  = r_o_log;
    assign o_res.last_of_frame  = r_o_lof;

    assign o_sts.phase    = r_phase;
    assign o_sts.grp_end  = grp_end;
    assign o_sts.div_done = div_done;
    assign o_sts.clr_last = r_clr_addr == PIX_W'(NPIX - 1);
    assign o_sts.out_xfer = r_out_valid && o_res.ready;
    assign o_sts.rp_last  = r_rp_j == eff_r - ROW_W'(1);
endmodule

FILE: rtl/pphf_ctrl.sv
// pphf_ctrl: sequencer for memory clear, sample update, group division and replay
// depends on pphf_pkg
module pphf_ctrl import pphf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:   if (i_sts.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid && i_sts.phase != PH_OFF) n_state = ST_RD;
            end
            ST_RD:    n_state = ST_PED;
            ST_PED:   n_state = ST_UPD;
            ST_UPD: begin
                if (i_sts.phase != PH_PED && i_sts.grp_end) n_state = ST_CM;
                else n_state = ST_IDLE;
            end
            ST_CM:    n_state = ST_CM_W;
            ST_CM_W: begin
                if (i_sts.div_done) n_state = (i_sts.phase == PH_OUT) ? ST_LIM : ST_RRD;
            end
            ST_LIM:   n_state = ST_LIM_W;
            ST_LIM_W: if (i_sts.div_done) n_state = ST_RRD;
            ST_RRD:   n_state = ST_RPED;
            ST_RPED:  n_state = ST_RSIG;
            ST_RSIG:  n_state = ST_RSQ;
            ST_RSQ:   n_state = ST_REVAL;
            ST_REVAL: begin
                if (i_sts.phase == PH_OUT) n_state = ST_RLOAD;
                else n_state = i_sts.rp_last ? ST_IDLE : ST_RRD;
            end
            ST_RLOAD: n_state = ST_RWAIT;
            ST_RWAIT: begin
                if (i_sts.out_xfer) n_state = i_sts.rp_last ? ST_IDLE : ST_RRD;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLR:   o_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_RD:    ;
            ST_PED:   o_cmd.ped_calc = 1'b1;
            ST_UPD: begin
                o_cmd.smp_upd = 1'b1;
                o_cmd.adv     = !(i_sts.phase != PH_PED && i_sts.grp_end);
            end
            ST_CM: begin
                o_cmd.cm_start = 1'b1;
                o_cmd.rp_init  = 1'b1;
            end
            ST_CM_W:  o_cmd.cm_load = i_sts.div_done;
            ST_LIM:   o_cmd.lim_start = 1'b1;
            ST_LIM_W: o_cmd.lim_load = i_sts.div_done;
            ST_RRD:   o_cmd.rd_rp = 1'b1;
            ST_RPED: begin
                o_cmd.rd_rp    = 1'b1;
                o_cmd.ped_calc = 1'b1;
            end
            ST_RSIG: begin
                o_cmd.rd_rp    = 1'b1;
                o_cmd.sig_calc = 1'b1;
            end
            ST_RSQ: begin
                o_cmd.rd_rp   = 1'b1;
                o_cmd.sq_calc = 1'b1;
            end
            ST_REVAL: begin
                o_cmd.rd_rp   = 1'b1;
                o_cmd.eval    = 1'b1;
                o_cmd.rp_step = i_sts.phase != PH_OUT;
                o_cmd.adv     = i_sts.phase != PH_OUT && i_sts.rp_last;
            end
            ST_RLOAD: begin
                o_cmd.rd_rp    = 1'b1;
                o_cmd.out_load = 1'b1;
            end
            ST_RWAIT: begin
                o_cmd.rd_rp   = 1'b1;
                o_cmd.rp_step = i_sts.out_xfer;
                o_cmd.adv     = i_sts.out_xfer && i_sts.rp_last;
            end
            default:  ;
        endcase
    end
endmodule

FILE: rtl/pixel_pedestal_common_mode_hit_finder.sv
// pixel_pedestal_common_mode_hit_finder: top level, sequencer plus datapath
// the last sample of a common mode group runs the common mode division (and the hot
// limit division in the output phase) and then replays the group pixel by pixel, held
// by any output stall in the output phase; after reset the sum memories are cleared,
// one entry a cycle over all MAX_ROWS*MAX_COLS entries (4096 by default), while no
// sample is taken; configuration writes are taken throughout
// depends on pphf_pkg, pphf_in_if, pphf_out_if, pphf_ctrl and pphf_dp
module pixel_pedestal_common_mode_hit_finder import pphf_pkg::*; #(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    pphf_in_if.sink           i_pix,
    pphf_out_if.source        o_res
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_pix.ready = w_in_ready;

    pphf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    pphf_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_pix.sample),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (o_res)
    );
endmodule

FILE: verif/pixel_pedestal_common_mode_hit_finder_test.sv
// pixel_pedestal_common_mode_hit_finder_test: self-checking testbench of the pedestal,
// common mode and hit finder block, with a scoreboard class that predicts every pixel result
// depends on pphf_pkg, pphf_in_if, pphf_out_if and pixel_pedestal_common_mode_hit_finder
module pixel_pedestal_common_mode_hit_finder_test;
    import pphf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [SIG_W-1:0] sig;
        logic                    hit;
        logic                    hot;
        logic                    on_edge;
        logic [MASK_W-1:0]       mask;
        logic                    grp_last;
        logic                    frm_last;
    } t_pix_res;

    class hit_predictor;
        bit [31:0]   ped_sum [4096];
        bit [55:0]   noise_sum [4096];
        bit [15:0]   grp_smp [64];
        longint      grp_acc;
        int unsigned pix_cnt, frame_cnt;
        bit [63:0]   noise_tot;
        bit [47:0]   hot_lim;
        t_phase      ph;
        int unsigned rows_r, cols_r, flog_r;
        t_pix_res    pending_pixels [$];
        int          errors;

        function new();
            ph = PH_PED; rows_r = 64; cols_r = 64; flog_r = 10;
            grp_acc = 0; pix_cnt = 0; frame_cnt = 0;
            noise_tot = 0; hot_lim = 0; errors = 0;
        endfunction

        function int unsigned eff_rows();
            return rows_r < 1 ? 1 : (rows_r > 64 ? 64 : rows_r);
        endfunction

        function int unsigned eff_cols();
            return cols_r < 1 ? 1 : (cols_r > 64 ? 64 : cols_r);
        endfunction

        function int unsigned eff_flog();
            return flog_r > 16 ? 16 : flog_r;
        endfunction

        function void restart();
            pix_cnt = 0;
            grp_acc = 0;
        endfunction

        function void apply_reg(t_cfg_idx idx, int unsigned v);
            case (idx)
                CFG_PHASE: begin
                    ph = t_phase'(v[1:0]); restart(); frame_cnt = 0;
                end
                CFG_ROWS: begin rows_r = v & 'h7f; restart(); end
                CFG_COLS: begin cols_r = v & 'h7f; restart(); end
                default:  flog_r = v & 'h1f;
            endcase
        endfunction

        function longint pix_diff(int unsigned i, int unsigned s);
            bit [63:0] pd;
            pd = ({32'd0, ped_sum[i]} << 4) >> eff_flog();
            if (pd > 64'd65535 * 16) pd = 64'd65535 * 16;
            return longint'(s) * 16 - longint'(pd);
        endfunction

        function bit [47:0] calc_limit(int unsigned n);
            bit [63:0] two_n, q, r, lim;
            two_n = 2 * n;
            q = noise_tot / two_n;
            r = noise_tot % two_n;
            if (q >= (64'd1 << 48)) return '1;
            lim = 17 * q + (17 * r) / two_n;
            if (lim > 64'hffff_ffff_ffff) lim = 64'hffff_ffff_ffff;
            return lim[47:0];
        endfunction

        function void take_sample(bit [15:0] s);
            int unsigned rr, cc, n, f, p, pos, base, idx, r, c;
            bit          acc, is_hot, is_hit;
            bit [63:0]   t, mag, sq;
            longint      cm, sig;
            t_pix_res    e;
            rr = eff_rows(); cc = eff_cols(); n = rr * cc; f = eff_flog();
            if (ph == PH_OFF) return;
            if (pix_cnt >= n) restart();
            p = pix_cnt;
            acc = frame_cnt < (1 << f);
            if (ph == PH_PED) begin
                if (acc) begin
                    t = {32'd0, ped_sum[p]} + s;
                    ped_sum[p] = t > 64'hffff_ffff ? 32'hffff_ffff : t[31:0];
                end
            end else begin
                pos = p % rr;
                grp_smp[pos] = s;
                grp_acc += pix_diff(p, s);
                if (pos == rr - 1) begin
                    base = p - pos;
                    cm = grp_acc / longint'(rr);
                    if ((grp_acc % longint'(rr)) != 0 && grp_acc < 0) cm -= 1;
                    if (ph == PH_OUT) hot_lim = calc_limit(n);
                    for (int j = 0; j < rr; j++) begin
                        idx = base + j;
                        sig = pix_diff(idx, grp_smp[j]) - cm;
                        if (sig > SIG_MAX) sig = SIG_MAX;
                        if (sig < SIG_MIN) sig = SIG_MIN;
                        mag = sig < 0 ? -sig : sig;
                        sq = mag * mag;
                        if (ph == PH_NOISE) begin
                            if (acc) begin
                                t = noise_sum[idx] + sq;
                                noise_sum[idx] = t > 64'h00ff_ffff_ffff_ffff ? '1 : t[55:0];
                                noise_tot = (noise_tot > ~64'd0 - sq) ? ~64'd0 : noise_tot + sq;
                            end
                        end else begin
                            r = idx / cc; c = idx % cc;
                            is_hot = noise_sum[idx] > hot_lim;
                            is_hit = !is_hot && ((sq << f) > 9 * {8'd0, noise_sum[idx]});
                            e.mask = 8'h00;
                            if (is_hit) begin
                                e.mask = 8'hff;
                                if (r == 0) e.mask &= 8'h1f;
                                if (c == 0) e.mask &= 8'hd6;
                                if (r == rr - 1) e.mask &= 8'hf8;
                                if (c == cc - 1) e.mask &= 8'h6b;
                            end
                            e.idx = idx[11:0];
                            e.sig = sig[20:0];
                            e.hit = is_hit;
                            e.hot = is_hot;
                            e.on_edge = (r == 0 || c == 0 || r == rr - 1 || c == cc - 1);
                            e.grp_last = (j == rr - 1);
                            e.frm_last = (idx == n - 1);
                            pending_pixels.push_back(e);
                        end
                    end
                    grp_acc = 0;
                end
            end
            pix_cnt++;
            if (pix_cnt >= n) begin
                restart();
                if (frame_cnt < 131071) frame_cnt++;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(t_pix_res got);
            t_pix_res e;
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected result for pixel %0d", got.idx));
                return;
            end
            e = pending_pixels.pop_front();
            if (got !== e)
                report($sformatf({"pixel %0d/%0d sig %0d/%0d hit %b/%b hot %b/%b edge %b/%b ",
                    "mask %h/%h lg %b/%b lf %b/%b"}, got.idx, e.idx, got.sig, e.sig,
                    got.hit, e.hit, got.hot, e.hot, got.on_edge, e.on_edge, got.mask, e.mask,
                    got.grp_last, e.grp_last, got.frm_last, e.frm_last));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    pphf_in_if  pix ();
    pphf_out_if res ();

    pixel_pedestal_common_mode_hit_finder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    hit_predictor sb = new();
    bit           gaps_on;
    int           stall_left;
    int           sent;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // output side back-pressure
    always @(negedge i_clk) begin
        if (!gaps_on) begin
            res.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.check_result('{res.pixel_index, res.signal, res.hit, res.hot, res.edge_res,
                              res.neighbour_mask, res.last_of_group, res.last_of_frame});
    end

    task push_sample(input bit [15:0] s);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        pix.valid  <= 1'b1;
        pix.sample <= s;
        do @(posedge i_clk); while (!pix.ready);
        sb.take_sample(s);
        sent++;
    endtask

    task write_reg(t_cfg_idx idx, int unsigned v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[CFG_DW-1:0];
        @(posedge i_clk);
        sb.apply_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task drain();
        @(negedge i_clk);
        pix.valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
    endtask

    function bit [15:0] noisy_sample(int base);
        int v;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 65535);
            1:       v = base + $urandom_range(0, 3000);
            default: v = base + $urandom_range(0, 8) - 4;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    task run_frames(int unsigned n, int frames, int base);
        int extra;
        for (int i = 0; i < frames * n; i++) push_sample(noisy_sample(base));
        // broken frame now and then
        if ($urandom_range(0, 5) == 0) begin
            extra = $urandom_range(1, n);
            for (int i = 0; i < extra; i++) push_sample(noisy_sample(base));
        end
    endtask

    initial begin
        int unsigned rr, cc, fl, n, nf;
        int          base, it;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_PHASE;
        i_cfg_data = '0;
        pix.valid  = 1'b0;
        pix.sample = '0;
        res.ready  = 1'b0;
        gaps_on    = 1'b1;
        stall_left = 0;
        sent       = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 2x2 frame, extreme samples, extra frame, ignored phase
        write_reg(CFG_ROWS, 2);
        write_reg(CFG_COLS, 2);
        write_reg(CFG_FLOG, 1);
        write_reg(CFG_PHASE, PH_PED);
        for (int i = 0; i < 12; i++) push_sample(i[0] ? 16'hffff : 16'h0000);
        drain();
        write_reg(CFG_PHASE, PH_NOISE);
        for (int i = 0; i < 8; i++) push_sample(i[1] ? 16'h0001 : 16'hfffe);
        drain();
        write_reg(CFG_PHASE, PH_OUT);
        push_sample(16'h0000); push_sample(16'hffff);
        push_sample(16'h8000); push_sample(16'h7fff);
        drain();
        write_reg(CFG_PHASE, PH_OFF);
        push_sample(16'h5555); push_sample(16'haaaa);
        drain();

        it = 0;
        while (sent < 300) begin
            if (it == 0) begin
                rr = 127; cc = 0; fl = 31;
            end else begin
                rr = $urandom_range(1, 4);
                cc = $urandom_range(1, 4);
                case ($urandom_range(0, 5))
                    0:       fl = 16;
                    1:       fl = 2;
                    2:       fl = 0;
                    default: fl = 1;
                endcase
            end
            gaps_on = (sent < 200) && ($urandom_range(0, 3) != 0);
            write_reg(CFG_ROWS, rr);
            write_reg(CFG_COLS, cc);
            write_reg(CFG_FLOG, fl);
            rr = sb.eff_rows(); cc = sb.eff_cols(); n = rr * cc;
            nf = (sb.eff_flog() <= 2) ? (1 << sb.eff_flog()) : 1;
            base = $urandom_range(0, 65535);
            write_reg(CFG_PHASE, PH_PED);
            run_frames(n, nf + ((it == 0) ? 0 : $urandom_range(0, 1)), base);
            drain();
            write_reg(CFG_PHASE, PH_NOISE);
            run_frames(n, nf + ((it == 0) ? 0 : $urandom_range(0, 1)), base);
            drain();
            write_reg(CFG_PHASE, PH_OUT);
            run_frames(n, (it == 0) ? 1 : $urandom_range(1, 2), base);
            drain();
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_PHASE, PH_OFF);
                push_sample(16'($urandom_range(0, 65535)));
                drain();
            end
            it++;
        end
        gaps_on = 1'b0;
        drain();

        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/pphf_pkg.sv
rtl/pphf_in_if.sv
rtl/pphf_out_if.sv
rtl/pphf_div.sv
rtl/pphf_dp.sv
rtl/pphf_ctrl.sv
rtl/pixel_pedestal_common_mode_hit_finder.sv
verif/pixel_pedestal_common_mode_hit_finder_test.sv
